FILE: design/bcsf_pkg.sv
// ----------------------------------------------------------------------------
// bcsf_pkg
// Shared widths, fixed-point constants and a table builder for the per-site
// base count feature pipeline.
// ----------------------------------------------------------------------------
package bcsf_pkg;

   // field widths of the request and response items
   localparam int COUNT_W = 16;
   localparam int REF_W   = 2;
   localparam int RATIO_W = 36;
   localparam int VAR_W   = 19;
   localparam int MEAN_W  = 19;

   // parameter defaults
   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Q32 log constants, ln(0.1) and ln(1.9)
   localparam logic signed [RATIO_W-1:0] LN_TENTH_Q32    = -36'sd9889527671;
   localparam logic signed [RATIO_W-1:0] LN_ONE_NINE_Q32 = 36'sd2756741450;

   // common denominator of the variance cases k*(k-1) for k = 2, 3, 4
   localparam int VarDen = 12;

   typedef logic [15:0][VAR_W-1:0] var_table_type;

   // variance of the occupied positions, one entry per nonzero-count mask
   function automatic var_table_type var_table(input int frac);
      var_table_type tbl;
      int            k;
      int            psum;
      int            psq;
      int            n;
      int            scaled;
      longint        num;
      for (int m = 0; m < 16; m++) begin
         k    = 0;
         psum = 0;
         psq  = 0;
         for (int i = 0; i < 4; i++) begin
            if (m[i]) begin
               k    = k + 1;
               psum = psum + i + 1;
               psq  = psq + (i + 1) * (i + 1);
            end
         end
         n = k * psq - psum * psum;
         case (k)
            2:       scaled = n * 6;
            3:       scaled = n * 2;
            4:       scaled = n;
            default: scaled = 0;
         endcase
         num    = (longint'(scaled) <<< frac) + longint'(VarDen / 2);
         tbl[m] = VAR_W'(num / VarDen);
      end
      return tbl;
   endfunction

endpackage

FILE: design/bcsf_req_if.sv
// ----------------------------------------------------------------------------
// bcsf_req_if
// Request channel: four base counts and the reference base of one site.
// ----------------------------------------------------------------------------
interface bcsf_req_if
   import bcsf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count_a;
   logic [COUNT_W-1:0] count_c;
   logic [COUNT_W-1:0] count_g;
   logic [COUNT_W-1:0] count_t;
   logic [REF_W-1:0]   ref_base;

   modport source (output valid, count_a, count_c, count_g, count_t, ref_base,
                   input ready);
   modport sink   (input valid, count_a, count_c, count_g, count_t, ref_base,
                   output ready);
endinterface

FILE: design/bcsf_rsp_if.sv
// ----------------------------------------------------------------------------
// bcsf_rsp_if
// Response channel: all features of one site.
// ----------------------------------------------------------------------------
interface bcsf_rsp_if
   import bcsf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [COUNT_W-1:0]        ref_count;
   logic [COUNT_W-1:0]        alt_first;
   logic [COUNT_W-1:0]        alt_second;
   logic [COUNT_W-1:0]        alt_third;
   logic signed [RATIO_W-1:0] log_error_ratio;
   logic [VAR_W-1:0]          position_variance;
   logic [MEAN_W-1:0]         position_mean;
   logic                      ref_is_max;
   logic                      ref_balanced;

   modport source (output valid, ref_count, alt_first, alt_second, alt_third,
                   log_error_ratio, position_variance, position_mean,
                   ref_is_max, ref_balanced,
                   input ready);
   modport sink   (input valid, ref_count, alt_first, alt_second, alt_third,
                   log_error_ratio, position_variance, position_mean,
                   ref_is_max, ref_balanced,
                   output ready);
endinterface

FILE: design/bcsf_div.sv
// ----------------------------------------------------------------------------
// bcsf_div
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload and a valid bit carried alongside each stage.
// ----------------------------------------------------------------------------
module bcsf_div
   import bcsf_pkg::*;
#(
   parameter int NUM_BITS  = 36,
   parameter int DEN_BITS  = 18,
   parameter int QUO_BITS  = 19,
   parameter int SIDE_BITS = 121
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [DEN_BITS-1:0]  den,
   input  logic [SIDE_BITS-1:0] side,
   output logic                 out_valid,
   output logic [QUO_BITS-1:0]  quo,
   output logic [SIDE_BITS-1:0] side_out
);

   localparam int RemBits = DEN_BITS + QUO_BITS;

   logic                 vld_ff  [QUO_BITS];
   logic [RemBits-1:0]   rem_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff  [QUO_BITS];
   logic [DEN_BITS-1:0]  den_ff  [QUO_BITS];
   logic [SIDE_BITS-1:0] side_ff [QUO_BITS];

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic                 vld_prev;
      logic [RemBits-1:0]   rem_prev;
      logic [QUO_BITS-1:0]  quo_prev;
      logic [DEN_BITS-1:0]  den_prev;
      logic [SIDE_BITS-1:0] side_prev;
      logic [RemBits-1:0]   trial;
      logic [RemBits-1:0]   rem_in;
      logic [QUO_BITS-1:0]  quo_in;

      // stage input: ports for the first stage, previous stage otherwise
      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = RemBits'(num);
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign side_prev = side;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // trial subtract of the shifted divisor for this quotient bit
      always_comb begin
         trial  = RemBits'(den_prev) << (QUO_BITS - 1 - j);
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= trial) begin
            rem_in                   = rem_prev - trial;
            quo_in[QUO_BITS - 1 - j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_BITS-1];
   assign quo       = quo_ff[QUO_BITS-1];
   assign side_out  = side_ff[QUO_BITS-1];

endmodule

FILE: design/base_count_site_features.sv
// ----------------------------------------------------------------------------
// base_count_site_features
// Per-site read count features: reference count, top three alternate counts,
// log error ratio, positional variance and mean, and two comparison flags.
// ----------------------------------------------------------------------------
// request to response: stage 1, stage 2, stage 3, the mean divider stages, output register
// throughput: one request per cycle when not stalled; the mean divider retires
//    one quotient bit per stage, so its FRAC_BITS + 3 stages set the latency
// a stalled response holds the whole pipeline in place
// reset (synchronous) clears every stage valid bit; no other state
// ----------------------------------------------------------------------------
module base_count_site_features
   import bcsf_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bcsf_req_if.sink   req_chan,
   bcsf_rsp_if.source rsp_chan
);

   localparam int CW        = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
   localparam int TW        = CW + 2;              // total, nonref
   localparam int WW        = CW + 4;              // weighted position sum
   localparam int NB        = WW + FRAC_BITS;      // divider numerator
   localparam int QB        = FRAC_BITS + 3;       // mean quotient bits
   localparam int SW        = CW + 39;             // log ratio products
   localparam int Sh        = 32 - FRAC_BITS;
   localparam int SideBits  = 4 * COUNT_W + RATIO_W + VAR_W + 2;
   localparam var_table_type VarTable = var_table(FRAC_BITS);

   logic en;
   logic out_v_ff;

   // pipeline advances whenever the output register can take a response
   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- stage 1: sums, reference select, max ----------------
   logic          v1_ff;
   logic [CW-1:0] cnt1_ff [4];
   logic [CW-1:0] cnt_in  [4];
   logic [REF_W-1:0] ref1_ff;
   logic [TW-1:0] total1_ff, total1_in;
   logic [WW-1:0] weight1_ff, weight1_in;
   logic [CW-1:0] maxc1_ff, maxc1_in;
   logic [CW-1:0] refc1_ff, refc1_in;
   logic [3:0]    mask1_ff, mask1_in;

   always_comb begin
      cnt_in[0]  = req_chan.count_a[CW-1:0];
      cnt_in[1]  = req_chan.count_c[CW-1:0];
      cnt_in[2]  = req_chan.count_g[CW-1:0];
      cnt_in[3]  = req_chan.count_t[CW-1:0];
      total1_in  = TW'(cnt_in[0]) + TW'(cnt_in[1]) + TW'(cnt_in[2]) + TW'(cnt_in[3]);
      weight1_in = WW'(cnt_in[0]) + (WW'(cnt_in[1]) << 1)
                 + WW'(cnt_in[2]) + (WW'(cnt_in[2]) << 1) + (WW'(cnt_in[3]) << 2);
      maxc1_in   = cnt_in[0];
      for (int i = 1; i < 4; i++) begin
         if (cnt_in[i] > maxc1_in) maxc1_in = cnt_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         mask1_in[i] = (cnt_in[i] != '0);
      end
      refc1_in = cnt_in[req_chan.ref_base];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) cnt1_ff[i] <= cnt_in[i];
         ref1_ff    <= req_chan.ref_base;
         total1_ff  <= total1_in;
         weight1_ff <= weight1_in;
         maxc1_ff   <= maxc1_in;
         refc1_ff   <= refc1_in;
         mask1_ff   <= mask1_in;
      end
   end

   // ---------------- stage 2: products, sort, flags, divider setup ----------------
   logic                 v2_ff;
   logic signed [SW-1:0] prod_a2_ff, prod_a2_in;
   logic signed [SW-1:0] prod_b2_ff, prod_b2_in;
   logic [CW-1:0]        alt2_ff [3];
   logic [CW-1:0]        srt     [4];
   logic [CW-1:0]        tmp;
   logic [CW-1:0]        refc2_ff;
   logic                 is_max2_ff, is_max2_in;
   logic                 bal2_ff, bal2_in;
   logic [VAR_W-1:0]     var2_ff;
   logic [NB-1:0]        num2_ff, num2_in;
   logic [TW-1:0]        den2_ff, den2_in;
   logic [TW-1:0]        nonref;

   always_comb begin
      nonref     = total1_ff - TW'(refc1_ff);
      prod_a2_in = SW'($signed({1'b0, nonref})) * SW'(LN_TENTH_Q32);
      prod_b2_in = SW'($signed({1'b0, refc1_ff})) * SW'(LN_ONE_NINE_Q32);

      // reference slot zeroed, then a five-compare descending sort network
      for (int i = 0; i < 4; i++) begin
         srt[i] = (ref1_ff == REF_W'(i)) ? '0 : cnt1_ff[i];
      end
      tmp = '0;
      if (srt[0] < srt[1]) begin tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp; end
      if (srt[2] < srt[3]) begin tmp = srt[2]; srt[2] = srt[3]; srt[3] = tmp; end
      if (srt[0] < srt[2]) begin tmp = srt[0]; srt[0] = srt[2]; srt[2] = tmp; end
      if (srt[1] < srt[3]) begin tmp = srt[1]; srt[1] = srt[3]; srt[3] = tmp; end
      if (srt[1] < srt[2]) begin tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp; end

      is_max2_in = (refc1_ff == maxc1_ff);
      bal2_in    = (TW'(refc1_ff) == nonref) || (TW'(refc1_ff) == nonref + TW'(1))
                || (nonref == TW'(refc1_ff) + TW'(1));

      // mean division with rounding offset; an empty site divides zero by one
      if (total1_ff == '0) begin
         num2_in = '0;
         den2_in = TW'(1);
      end else begin
         num2_in = (NB'(weight1_ff) << FRAC_BITS) + NB'(total1_ff >> 1);
         den2_in = total1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a2_ff <= prod_a2_in;
         prod_b2_ff <= prod_b2_in;
         for (int i = 0; i < 3; i++) alt2_ff[i] <= srt[i];
         refc2_ff   <= refc1_ff;
         is_max2_ff <= is_max2_in;
         bal2_ff    <= bal2_in;
         var2_ff    <= VarTable[mask1_ff];
         num2_ff    <= num2_in;
         den2_ff    <= den2_in;
      end
   end

   // ---------------- stage 3: log ratio sum and rounding ----------------
   logic                      v3_ff;
   logic signed [SW-1:0]      sum3;
   logic signed [RATIO_W-1:0] ratio3_ff;
   logic [SideBits-1:0]       side3_ff;
   logic [NB-1:0]             num3_ff;
   logic [TW-1:0]             den3_ff;

   assign sum3 = prod_a2_ff + prod_b2_ff + (SW'(1) <<< (Sh - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ratio3_ff <= RATIO_W'(sum3 >>> Sh);
         side3_ff  <= {COUNT_W'(refc2_ff), COUNT_W'(alt2_ff[0]), COUNT_W'(alt2_ff[1]),
                       COUNT_W'(alt2_ff[2]), RATIO_W'(0), var2_ff, is_max2_ff, bal2_ff};
         num3_ff   <= num2_ff;
         den3_ff   <= den2_ff;
      end
   end

   // ---------------- mean divider ----------------
   logic                div_v;
   logic [QB-1:0]       div_q;
   logic [SideBits-1:0] div_side;
   logic [SideBits-1:0] side3_full;

   // ratio slot filled here so it rides with the rest of the features
   always_comb begin
      side3_full = side3_ff;
      side3_full[VAR_W + 2 +: RATIO_W] = ratio3_ff;
   end

   bcsf_div #(
      .NUM_BITS  (NB),
      .DEN_BITS  (TW),
      .QUO_BITS  (QB),
      .SIDE_BITS (SideBits)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .num       (num3_ff),
      .den       (den3_ff),
      .side      (side3_full),
      .out_valid (div_v),
      .quo       (div_q),
      .side_out  (div_side)
   );

   // ---------------- output register ----------------
   logic [SideBits-1:0] side_o_ff;
   logic [MEAN_W-1:0]   mean_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_o_ff <= div_side;
         mean_o_ff <= MEAN_W'(div_q);
      end
   end

   assign rsp_chan.valid             = out_v_ff;
   assign rsp_chan.ref_count         = side_o_ff[SideBits-1 -: COUNT_W];
   assign rsp_chan.alt_first         = side_o_ff[SideBits-1-COUNT_W -: COUNT_W];
   assign rsp_chan.alt_second        = side_o_ff[SideBits-1-2*COUNT_W -: COUNT_W];
   assign rsp_chan.alt_third         = side_o_ff[SideBits-1-3*COUNT_W -: COUNT_W];
   assign rsp_chan.log_error_ratio   = side_o_ff[VAR_W + 2 +: RATIO_W];
   assign rsp_chan.position_variance = side_o_ff[2 +: VAR_W];
   assign rsp_chan.position_mean     = mean_o_ff;
   assign rsp_chan.ref_is_max        = side_o_ff[1];
   assign rsp_chan.ref_balanced      = side_o_ff[0];

endmodule

FILE: test/tb_base_count_site_features.sv
// ----------------------------------------------------------------------------
// tb_base_count_site_features
// Drives site requests through the feature block with random idling on both
// sides, predicts every response in the bench and compares all of its fields.
// ----------------------------------------------------------------------------
module tb_base_count_site_features;
   import bcsf_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] a;
      logic [COUNT_W-1:0] c;
      logic [COUNT_W-1:0] g;
      logic [COUNT_W-1:0] t;
      logic [REF_W-1:0]   rb;
   } site_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        refc;
      logic [COUNT_W-1:0]        alt1;
      logic [COUNT_W-1:0]        alt2;
      logic [COUNT_W-1:0]        alt3;
      logic signed [RATIO_W-1:0] ratio;
      logic [VAR_W-1:0]          pvar;
      logic [MEAN_W-1:0]         pmean;
      logic                      is_max;
      logic                      balanced;
   } feat_type;

   typedef struct {
      site_type site;
      logic     known;
      feat_type feat;
   } row_type;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int N_RANDOM  = 1500;
   localparam int WATCHDOG  = 2000;
   localparam int LATENCY   = FRAC + 7;

   logic clock;
   logic reset;

   bcsf_req_if req_chan ();
   bcsf_rsp_if rsp_chan ();

   base_count_site_features DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   feat_type feature_queue[$];
   row_type  site_rows[$];
   int       mismatches;
   int       responses;
   int       idle_cycles;
   logic     sending_done;
   logic     no_idle;

   // features of one site
   function automatic feat_type site_features(site_type s);
      feat_type          f;
      logic [63:0]       cnt[4];
      logic [63:0]       alt[4];
      logic [63:0]       tmp;
      logic [63:0]       total, weighted, maxc, k, psum, psq, refc, nonref;
      logic [63:0]       num, den, diff;
      logic signed [63:0] sum;
      cnt[0] = 64'(s.a); cnt[1] = 64'(s.c); cnt[2] = 64'(s.g); cnt[3] = 64'(s.t);
      total = '0; weighted = '0; maxc = '0; k = '0; psum = '0; psq = '0;
      for (int i = 0; i < 4; i++) begin
         total    += cnt[i];
         weighted += 64'(i + 1) * cnt[i];
         if (cnt[i] > maxc) maxc = cnt[i];
         if (cnt[i] != 0) begin
            k++;
            psum += 64'(i + 1);
            psq  += 64'((i + 1) * (i + 1));
         end
      end
      refc   = cnt[s.rb];
      nonref = total - refc;
      for (int i = 0; i < 4; i++) alt[i] = (i == s.rb) ? 64'd0 : cnt[i];
      // simple descending sort
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3 - i; j++)
            if (alt[j] < alt[j+1]) begin
               tmp = alt[j]; alt[j] = alt[j+1]; alt[j+1] = tmp;
            end
      // Q32 sum, round half up, arithmetic shift keeps the floor
      sum = $signed(nonref) * -64'sd9889527671 + $signed(refc) * 64'sd2756741450;
      sum = (sum + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
      f.ratio = sum[RATIO_W-1:0];
      f.pvar  = '0;
      if (k >= 2) begin
         num    = (k * psq - psum * psum) << FRAC;
         den    = k * (k - 1);
         tmp    = (num + den / 2) / den;
         f.pvar = tmp[VAR_W-1:0];
      end
      f.pmean = '0;
      if (total != 0) begin
         tmp     = ((weighted << FRAC) + total / 2) / total;
         f.pmean = tmp[MEAN_W-1:0];
      end
      diff       = (refc > nonref) ? refc - nonref : nonref - refc;
      f.refc     = refc[15:0];
      f.alt1     = alt[0][15:0];
      f.alt2     = alt[1][15:0];
      f.alt3     = alt[2][15:0];
      f.is_max   = (refc == maxc);
      f.balanced = (diff <= 1);
      return f;
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'hffff;
         2:       return COUNT_W'($urandom_range(0, 3));
         3:       return COUNT_W'($urandom_range(0, 60));
         default: return COUNT_W'($urandom());
      endcase
   endfunction

   // directed rows, typed expectations where obvious
   task automatic add_row(site_type s, logic known, feat_type f);
      row_type r;
      r.site = s; r.known = known; r.feat = f;
      site_rows.insert(site_rows.size(), r);
   endtask

   task automatic build_table();
      feat_type f;
      site_type s;
      f = '0; f.is_max = 1'b1; f.balanced = 1'b1;
      for (int rb = 0; rb < 4; rb++) begin
         s = '0; s.rb = 2'(rb);
         add_row(s, 1'b1, f);            // no reads at all
      end
      for (int rb = 0; rb < 4; rb++) add_row({16'hffff, 16'hffff, 16'hffff,
                                               16'hffff, 2'(rb)}, 1'b0, f);
      add_row({16'hffff, 16'h0, 16'h0, 16'h0, 2'd0}, 1'b0, f);
      add_row({16'h0, 16'h0, 16'h0, 16'hffff, 2'd0}, 1'b0, f);
      add_row({16'h1, 16'h0, 16'h0, 16'h0, 2'd0}, 1'b0, f);
      add_row({16'h1, 16'h1, 16'h0, 16'h0, 2'd1}, 1'b0, f);
      add_row({16'h1, 16'h2, 16'h3, 16'h4, 2'd2}, 1'b0, f);
      add_row({16'h5, 16'h5, 16'h0, 16'h4, 2'd3}, 1'b0, f);
      add_row({16'haaaa, 16'h5555, 16'h0f0f, 16'hf0f0, 2'd1}, 1'b0, f);
      add_row({16'h0, 16'h8000, 16'h0, 16'h7fff, 2'd1}, 1'b0, f);
      add_row({16'h0, 16'h0, 16'h1, 16'h1, 2'd3}, 1'b0, f);
      add_row({16'h3, 16'h0, 16'h9, 16'h0, 2'd2}, 1'b0, f);
   endtask

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request side
   initial begin
      int n_idle;
      row_type r;
      reset = 1; sending_done = 0; no_idle = 0;
      req_chan.valid = 0;
      {req_chan.count_a, req_chan.count_c, req_chan.count_g, req_chan.count_t,
       req_chan.ref_base} = '0;
      build_table();
      for (int i = 0; i < N_RANDOM; i++) begin
         r.site = {rand_count(), rand_count(), rand_count(), rand_count(),
                   2'($urandom_range(0, 3))};
         r.known = 1'b0;
         site_rows.insert(site_rows.size(), r);
      end
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 0;
      foreach (site_rows[i]) begin
         if (i > site_rows.size() - 200) no_idle = 1;
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            n_idle = $urandom_range(1, 4);
            req_chan.valid <= 1'b0;
            repeat (n_idle) @(negedge clock);
         end
         req_chan.valid    <= 1'b1;
         req_chan.count_a  <= site_rows[i].site.a;
         req_chan.count_c  <= site_rows[i].site.c;
         req_chan.count_g  <= site_rows[i].site.g;
         req_chan.count_t  <= site_rows[i].site.t;
         req_chan.ref_base <= site_rows[i].site.rb;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         feature_queue.insert(feature_queue.size(),
                              site_rows[i].known ? site_rows[i].feat
                              : site_features(site_rows[i].site));
         @(negedge clock);
      end
      req_chan.valid <= 1'b0;
      sending_done = 1;
   end

   // response side stalls
   initial begin
      rsp_chan.ready = 0;
      @(negedge clock);
      forever begin
         if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // response check and watchdog
   initial begin
      feat_type want, got;
      mismatches = 0; responses = 0; idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.ref_count, rsp_chan.alt_first, rsp_chan.alt_second,
                   rsp_chan.alt_third, rsp_chan.log_error_ratio,
                   rsp_chan.position_variance, rsp_chan.position_mean,
                   rsp_chan.ref_is_max, rsp_chan.ref_balanced};
            responses++;
            if (feature_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
               want = feature_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch #%0d exp ref %h alt %h %h %h ratio %0d",
                        responses, want.refc, want.alt1, want.alt2, want.alt3,
                        want.ratio);
                     $display("   exp var %h mean %h max %b bal %b",
                        want.pvar, want.pmean, want.is_max, want.balanced);
                     $display("   got ref %h alt %h %h %h ratio %0d",
                        got.refc, got.alt1, got.alt2, got.alt3, got.ratio);
                     $display("   got var %h mean %h max %b bal %b",
                        got.pvar, got.pmean, got.is_max, got.balanced);
                  end
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (sending_done && feature_queue.size() == 0) begin
            repeat (LATENCY + 10) begin
               @(posedge clock);
               if (rsp_chan.valid && rsp_chan.ready) begin
                  mismatches++;
                  if (mismatches <= 10) $display("extra response after drain");
               end
            end
            $display("covered %0d site requests (%0d directed), %0d responses checked",
                     site_rows.size(), site_rows.size() - N_RANDOM, responses);
            if (mismatches == 0)
               $display("[base_count_site_features] OK");
            else
               $display("[base_count_site_features] ERROR");
            $finish;
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d responses pending", feature_queue.size());
            $display("[base_count_site_features] ERROR");
            $finish;
         end
      end
   end

endmodule
